/* rtl/core/assert_macros.svh */
// Assertion macros shared by the text rasterizer RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BTLR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
`define BTLR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `BTLR_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define BTLR_ASSERT(lbl, clk, rst_n, prop)
`define BTLR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/core/btlr_pkg.sv */
// Shared types and constants of the bitmap text layout rasterizer.
// No dependencies.
`timescale 1ns / 1ps

package btlr_pkg;

  localparam int SCREEN_W_BITS = 12;
  localparam int FONT_BITS     = 6;
  localparam int COLOR_BITS    = 16;
  localparam int BACK_BITS     = 17;
  localparam int ACTION_BITS   = 2;
  localparam int CODE_BITS     = 16;
  localparam int ROW_BITS      = 32;
  localparam int COL_IDX_BITS  = 5;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [SCREEN_W_BITS-1:0] SCREEN_W_RESET = 12'd320;
  localparam logic [FONT_BITS-1:0]     FONT_RESET     = 6'd16;
  localparam logic [COLOR_BITS-1:0]    TEXT_RESET     = 16'hFFFF;
  localparam logic [BACK_BITS-1:0]     BACK_RESET     = 17'h1FFFF;

  localparam logic [CODE_BITS-1:0] CP_CR       = 16'd13;
  localparam logic [CODE_BITS-1:0] CP_LF       = 16'd10;
  localparam logic [CODE_BITS-1:0] CP_TAB      = 16'd9;
  localparam logic [CODE_BITS-1:0] CP_HALF_MAX = 16'd127;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_START = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_ROW   = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH = 2'd0,
    REG_CELL_SIZE    = 2'd1,
    REG_TEXT_COLOR   = 2'd2,
    REG_BACK_COLOR   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SCREEN_W_BITS-1:0] screen_width;
    logic [FONT_BITS-1:0]     cell_size;
    logic [COLOR_BITS-1:0]    text_color;
    logic [BACK_BITS-1:0]     back_color;  // bit 16 set: transparent
  } cfg_t;

endpackage

/* rtl/core/btlr_front.sv */
// Front end: accepts words, keeps the text cursor and glyph cell, and turns
// live glyph rows into row jobs for the queue. Uses btlr_pkg.
`timescale 1ns / 1ps

module btlr_front #(
  parameter int MAX_CELL_SIZE = 32,
  parameter int COORD_BITS    = 12,
  localparam int JOB_W = 2 * COORD_BITS + 2 * btlr_pkg::ROW_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  btlr_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [btlr_pkg::ACTION_BITS-1:0]    action_i,
  input  logic [COORD_BITS-1:0]               pos_x_i,
  input  logic [COORD_BITS-1:0]               pos_y_i,
  input  logic [btlr_pkg::CODE_BITS-1:0]      code_point_i,
  input  logic [btlr_pkg::ROW_BITS-1:0]       row_bits_i,
  input  logic                                full_i,
  output logic                                push_o,
  output logic [JOB_W-1:0]                    job_o
);

  localparam int CMPW = (COORD_BITS >= btlr_pkg::SCREEN_W_BITS) ?
                        COORD_BITS + 1 : btlr_pkg::SCREEN_W_BITS + 1;
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [6:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {{(COORD_BITS - 6){1'b0}}, b};
    return s[COORD_BITS] ? CMAX : s[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [COORD_BITS-1:0] glyph_x_q, glyph_x_d, glyph_y_q, glyph_y_d;
  logic [btlr_pkg::FONT_BITS-1:0] row_index_q, row_index_d;
  logic half_width_q, half_width_d, draw_enable_q, draw_enable_d;

  logic [btlr_pkg::FONT_BITS-1:0] fs, half_fs, adv, cols;
  logic [6:0]                     fs_p1, adv_p1;
  logic                           is_half, wrap, row_live, accept;
  logic [CMPW-1:0]                reach;
  logic [COORD_BITS-1:0]          wrap_x, wrap_y, row_y;
  logic [btlr_pkg::ROW_BITS-1:0]  col_mask, pix_mask;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (32'(cfg_i.cell_size) > MAX_CELL_SIZE) begin
      fs = btlr_pkg::FONT_BITS'(MAX_CELL_SIZE);
    end else begin
      fs = cfg_i.cell_size;
    end
    half_fs = fs >> 1;
    fs_p1   = {1'b0, fs} + 7'd1;
    is_half = code_point_i <= btlr_pkg::CP_HALF_MAX;
    adv     = is_half ? half_fs : fs;
    adv_p1  = {1'b0, adv} + 7'd1;
    reach   = CMPW'(cursor_x_q) + CMPW'(adv);
    wrap    = reach > CMPW'(cfg_i.screen_width);
    wrap_x  = wrap ? '0 : cursor_x_q;
    wrap_y  = wrap ? sat_add(cursor_y_q, fs_p1) : cursor_y_q;

    // columns drawn for the open glyph
    cols = (fs > 6'd32) ? 6'd32 : fs;
    if (half_width_q && (half_fs + 6'd1) < cols) begin
      cols = half_fs + 6'd1;
    end
    for (int i = 0; i < btlr_pkg::ROW_BITS; i++) begin
      col_mask[i] = 6'(i) < cols;
    end
    pix_mask = cfg_i.back_color[btlr_pkg::BACK_BITS-1] ? (row_bits_i & col_mask) : col_mask;
    row_y    = sat_add(glyph_y_q, {1'b0, row_index_q});
    row_live = draw_enable_q && (row_index_q < fs);
  end

  always_comb begin
    cursor_x_d    = cursor_x_q;
    cursor_y_d    = cursor_y_q;
    glyph_x_d     = glyph_x_q;
    glyph_y_d     = glyph_y_q;
    row_index_d   = row_index_q;
    half_width_d  = half_width_q;
    draw_enable_d = draw_enable_q;
    push_o        = 1'b0;
    if (accept) begin
      unique case (btlr_pkg::action_e'(action_i))
        btlr_pkg::ACT_START: begin
          cursor_x_d    = pos_x_i;
          cursor_y_d    = pos_y_i;
          draw_enable_d = 1'b0;
          row_index_d   = '0;
        end
        btlr_pkg::ACT_CHAR: begin
          if (code_point_i == btlr_pkg::CP_CR || code_point_i == btlr_pkg::CP_LF) begin
            cursor_x_d    = '0;
            cursor_y_d    = sat_add(cursor_y_q, fs_p1);
            draw_enable_d = 1'b0;
          end else if (code_point_i == btlr_pkg::CP_TAB) begin
            cursor_x_d    = sat_add(cursor_x_q, fs_p1);
            draw_enable_d = 1'b0;
          end else begin
            half_width_d  = is_half;
            glyph_x_d     = wrap_x;
            glyph_y_d     = wrap_y;
            cursor_y_d    = wrap_y;
            cursor_x_d    = sat_add(wrap_x, adv_p1);
            row_index_d   = '0;
            draw_enable_d = 1'b1;
          end
        end
        btlr_pkg::ACT_ROW: begin
          if (!row_live) begin
            draw_enable_d = 1'b0;
          end else begin
            push_o        = pix_mask != '0;
            row_index_d   = row_index_q + 6'd1;
            draw_enable_d = (row_index_q + 6'd1) < fs;
          end
        end
        default: begin
          // unused action: drop
        end
      endcase
    end
  end

  assign job_o = {glyph_x_q, row_y, row_bits_i, pix_mask};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q    <= '0;
      cursor_y_q    <= '0;
      glyph_x_q     <= '0;
      glyph_y_q     <= '0;
      row_index_q   <= '0;
      half_width_q  <= 1'b0;
      draw_enable_q <= 1'b0;
    end else begin
      cursor_x_q    <= cursor_x_d;
      cursor_y_q    <= cursor_y_d;
      glyph_x_q     <= glyph_x_d;
      glyph_y_q     <= glyph_y_d;
      row_index_q   <= row_index_d;
      half_width_q  <= half_width_d;
      draw_enable_q <= draw_enable_d;
    end
  end

endmodule

/* rtl/core/btlr_queue.sv */
// Short row-job queue between front and back end.
// Uses btlr_pkg for its depth and assert_macros.svh for checks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btlr_queue #(
  parameter int WIDTH = 88
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int DEPTH = btlr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_FULL;
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `BTLR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_FULL)
  `BTLR_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)

endmodule

/* rtl/core/btlr_back.sv */
// Back end: expands one row job into pixel writes, one per cycle while the output is not
// stalled, through an output register. Uses btlr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btlr_back #(
  parameter int COORD_BITS = 12,
  localparam int JOB_W = 2 * COORD_BITS + 2 * btlr_pkg::ROW_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  btlr_pkg::cfg_t                   cfg_i,
  input  logic                             job_valid_i,
  input  logic [JOB_W-1:0]                 job_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [COORD_BITS-1:0]            pixel_x_o,
  output logic [COORD_BITS-1:0]            pixel_y_o,
  output logic [btlr_pkg::COLOR_BITS-1:0]  color_o,
  output logic                             last_o
);

  localparam int RB = btlr_pkg::ROW_BITS;
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  logic [COORD_BITS-1:0]           wx_q, wy_q, px;
  logic [RB-1:0]                   wbits_q, wmask_q, low, mask_after;
  logic [btlr_pkg::COL_IDX_BITS-1:0] col;
  logic [COORD_BITS:0]             px_sum;
  logic [btlr_pkg::COLOR_BITS-1:0] pcolor;
  logic                            fire, plast;

  logic                            out_valid_q;
  logic [COORD_BITS-1:0]           out_x_q, out_y_q;
  logic [btlr_pkg::COLOR_BITS-1:0] out_color_q;
  logic                            out_last_q;

  always_comb begin
    // lowest pending column
    low = wmask_q & (~wmask_q + RB'(1));
    col = '0;
    for (int i = 0; i < RB; i++) begin
      if (low[i]) begin
        col = col | btlr_pkg::COL_IDX_BITS'(i);
      end
    end
    px_sum = {1'b0, wx_q} + (COORD_BITS + 1)'(col);
    px     = px_sum[COORD_BITS] ? CMAX : px_sum[COORD_BITS-1:0];
    pcolor = ((wbits_q & low) != '0) ? cfg_i.text_color :
             cfg_i.back_color[btlr_pkg::COLOR_BITS-1:0];
    plast  = (wmask_q & ~low) == '0;
    fire   = (wmask_q != '0) && (!out_valid_q || out_ready_i);
    mask_after = fire ? (wmask_q & ~low) : wmask_q;
    pop_o  = job_valid_i && (mask_after == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wmask_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wmask_q <= pop_o ? job_i[RB-1:0] : mask_after;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {wx_q, wy_q, wbits_q} <= job_i[JOB_W-1:RB];
    end
    if (fire) begin
      out_x_q     <= px;
      out_y_q     <= wy_q;
      out_color_q <= pcolor;
      out_last_q  <= plast;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign color_o     = out_color_q;
  assign last_o      = out_last_q;

  // a word that is not the last of its row leaves columns pending
  `BTLR_ASSERT(a_more_pending, clk_i, rst_ni, (out_valid_q && !out_last_q) |-> (wmask_q != '0))
  `BTLR_ASSERT(a_hold_on_stall, clk_i, rst_ni,
               (wmask_q != '0 && out_valid_q && !out_ready_i) |=> $stable(wmask_q))

endmodule

/* rtl/core/bitmap_text_layout_rasterizer.sv */
// Bitmap text layout rasterizer: layout front end, row queue and pixel back end.
// A glyph row word passes the row queue, the back end work registers and its output register.
// Throughput: one input word per cycle while the two-entry row queue has room; one pixel
// word per cycle out while out_ready_i is not held low, one for each drawn column of a row
// (up to 32, 16 for a full-width and 9 for a half-width glyph at font size 16).
// Reset clears cursor, glyph and queue state and loads the register defaults at once.
`timescale 1ns / 1ps

module bitmap_text_layout_rasterizer #(
  parameter int MAX_CELL_SIZE = 32,
  parameter int COORD_BITS    = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [btlr_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [btlr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [btlr_pkg::ACTION_BITS-1:0]    action_i,
  input  logic [COORD_BITS-1:0]               pos_x_i,
  input  logic [COORD_BITS-1:0]               pos_y_i,
  input  logic [btlr_pkg::CODE_BITS-1:0]      code_point_i,
  input  logic [btlr_pkg::ROW_BITS-1:0]       row_bits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [COORD_BITS-1:0]               pixel_x_o,
  output logic [COORD_BITS-1:0]               pixel_y_o,
  output logic [btlr_pkg::COLOR_BITS-1:0]     color_o,
  output logic                                last_o
);

  localparam int JOB_W = 2 * COORD_BITS + 2 * btlr_pkg::ROW_BITS;

  btlr_pkg::cfg_t   cfg_q;
  logic             push, full, job_valid, pop;
  logic [JOB_W-1:0] job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width <= btlr_pkg::SCREEN_W_RESET;
      cfg_q.cell_size    <= btlr_pkg::FONT_RESET;
      cfg_q.text_color   <= btlr_pkg::TEXT_RESET;
      cfg_q.back_color   <= btlr_pkg::BACK_RESET;
    end else if (cfg_we_i) begin
      unique case (btlr_pkg::cfg_reg_e'(cfg_index_i))
        btlr_pkg::REG_SCREEN_WIDTH:
          cfg_q.screen_width <= cfg_wdata_i[btlr_pkg::SCREEN_W_BITS-1:0];
        btlr_pkg::REG_CELL_SIZE:
          cfg_q.cell_size <= cfg_wdata_i[btlr_pkg::FONT_BITS-1:0];
        btlr_pkg::REG_TEXT_COLOR:
          cfg_q.text_color <= cfg_wdata_i[btlr_pkg::COLOR_BITS-1:0];
        btlr_pkg::REG_BACK_COLOR:
          cfg_q.back_color <= cfg_wdata_i[btlr_pkg::BACK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  btlr_front #(
    .MAX_CELL_SIZE(MAX_CELL_SIZE),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .code_point_i(code_point_i),
    .row_bits_i  (row_bits_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job_in)
  );

  btlr_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .data_o (job_out)
  );

  btlr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_x_o  (pixel_x_o),
    .pixel_y_o  (pixel_y_o),
    .color_o    (color_o),
    .last_o     (last_o)
  );

endmodule
